// ----- design/fla_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fla_pkg
// shared types and codes for the free list allocator with waiters
// ----------------------------------------------------------------------------
package fla_pkg;

  localparam int IdFieldW = 8;

  typedef enum logic [2:0] {
    FUNC_REL_FRONT = 3'd0,
    FUNC_REL_BACK  = 3'd1,
    FUNC_ALLOC     = 3'd2,
    FUNC_TRY       = 3'd3,
    FUNC_PEEK      = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    OUT_STORED   = 3'd0,
    OUT_GRANTED  = 3'd1,
    OUT_RETURNED = 3'd2,
    OUT_NONE     = 3'd3,
    OUT_PEEK     = 3'd4,
    OUT_OVERFLOW = 3'd5
  } outcome_t;

  typedef struct packed {
    func_t                func;
    logic [IdFieldW-1:0]  entry_id;
    logic [IdFieldW-1:0]  requester_id;
  } cmd_item_t;

  typedef struct packed {
    outcome_t             outcome;
    logic [IdFieldW-1:0]  entry_out;
    logic [IdFieldW-1:0]  waiter_out;
    logic                 available;
  } result_item_t;

  // per-cycle operation broadcast along the cell row
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop;
  } fla_op_t;

endpackage

// ----- design/fla_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fla_cell
// one slot of the deque row: shifts with its neighbours or loads the tail id
// ----------------------------------------------------------------------------
module fla_cell #(
  parameter int INDEX  = 0,
  parameter int CNT_W  = 7,
  parameter int CELL_W = 8
) (
  input  logic                 clk,
  input  fla_pkg::fla_op_t     op,
  input  logic [CNT_W-1:0]     count,
  input  logic [CELL_W-1:0]    new_id,
  input  logic [CELL_W-1:0]    left_val,
  input  logic [CELL_W-1:0]    right_val,
  output logic [CELL_W-1:0]    val
);
  import fla_pkg::*;

  localparam logic [CNT_W-1:0] MyIdx = CNT_W'(INDEX);

  always_ff @(posedge clk) begin
    if (op.push_front) begin
      val <= left_val;
    end else if (op.pop) begin
      val <= right_val;
    end else if (op.push_back && (count == MyIdx)) begin
      val <= new_id;
    end
  end

endmodule

// ----- design/free_list_allocator_with_waiters.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_list_allocator_with_waiters
// token allocator: one deque of free entry ids or waiting requester ids
// ----------------------------------------------------------------------------
// usage
//   an item (cmd) is taken at a rising edge with start high and busy low.
//   busy is held low: the block takes one item in every cycle.
//   each item gives exactly one result on result, marked by done for one
//   cycle, in the cycle right after the accepting edge (throughput 1 item per
//   cycle). the receiver cannot stall, so no result is ever held back and
//   nothing needs buffering.
//   storage is a row of LIST_DEPTH cells; the front of the deque is always
//   cell 0. push front and pop shift the whole row by one place, and push
//   back loads the cell whose index equals the fill count. every cell
//   updates in parallel on the edge.
//   at reset (rst, synchronous) the fill count clears and the list is in
//   free-entry mode; cell contents are left as they are, since a cell is
//   only read once it has been written.
// ----------------------------------------------------------------------------
module free_list_allocator_with_waiters #(
  parameter int LIST_DEPTH = 64,
  parameter int ID_WIDTH   = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  fla_pkg::cmd_item_t     cmd,
  output logic                   done,
  output fla_pkg::result_item_t  result
);
  import fla_pkg::*;

  // ids never need more bits than the item fields carry
  localparam int CELL_W = (ID_WIDTH < IdFieldW) ? ID_WIDTH : IdFieldW;
  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam logic [CNT_W-1:0] CntFull = CNT_W'(LIST_DEPTH);
  localparam logic [CNT_W-1:0] CntOne  = CNT_W'(1);

  // control state
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             holds_free;
  logic             holds_free_next;

  // cell row
  logic [CELL_W-1:0] cell_val [LIST_DEPTH];
  fla_op_t           op;
  logic [CELL_W-1:0] new_id;

  // decode helpers
  logic              accept;
  logic              empty;
  logic              full;
  logic [CELL_W-1:0] entry_m;
  logic [CELL_W-1:0] req_m;
  logic [CELL_W-1:0] front;
  result_item_t      res_next;

  assign busy    = 1'b0;
  assign accept  = start & ~busy;
  assign empty   = (count == '0);
  assign full    = (count == CntFull);
  assign entry_m = cmd.entry_id[CELL_W-1:0];
  assign req_m   = cmd.requester_id[CELL_W-1:0];
  assign front   = cell_val[0];

  // item decode: which way the row moves and what the result says
  always_comb begin
    op              = '0;
    new_id          = entry_m;
    holds_free_next = holds_free;
    res_next        = '0;
    res_next.outcome = OUT_PEEK;
    case (cmd.func)
      FUNC_REL_FRONT, FUNC_REL_BACK: begin
        if (holds_free || empty) begin
          // an empty waiter list falls back to free-entry mode
          holds_free_next = 1'b1;
          if (full) begin
            res_next.outcome = OUT_OVERFLOW;
          end else begin
            op.push_front    = (cmd.func == FUNC_REL_FRONT);
            op.push_back     = (cmd.func == FUNC_REL_BACK);
            res_next.outcome = OUT_STORED;
          end
        end else begin
          // hand the entry straight to the oldest waiter
          op.pop              = 1'b1;
          res_next.outcome    = OUT_GRANTED;
          res_next.entry_out  = IdFieldW'(entry_m);
          res_next.waiter_out = IdFieldW'(front);
          if (count == CntOne) begin
            holds_free_next = 1'b1;
          end
        end
      end
      FUNC_ALLOC: begin
        if (!holds_free || empty) begin
          if (full) begin
            res_next.outcome = OUT_OVERFLOW;
          end else begin
            op.push_back     = 1'b1;
            new_id           = req_m;
            holds_free_next  = 1'b0;
            res_next.outcome = OUT_STORED;
          end
        end else begin
          op.pop             = 1'b1;
          res_next.outcome   = OUT_RETURNED;
          res_next.entry_out = IdFieldW'(front);
        end
      end
      FUNC_TRY: begin
        if (holds_free && !empty) begin
          op.pop             = 1'b1;
          res_next.outcome   = OUT_RETURNED;
          res_next.entry_out = IdFieldW'(front);
        end else begin
          res_next.outcome = OUT_NONE;
        end
      end
      default: begin
        // peek and unused codes leave the state alone
        res_next.outcome = OUT_PEEK;
      end
    endcase
    if (!accept) begin
      op              = '0;
      holds_free_next = holds_free;
    end
    // fill count follows the row movement
    count_next = count;
    if (op.push_front || op.push_back) begin
      count_next = count + CntOne;
    end else if (op.pop) begin
      count_next = count - CntOne;
    end
    res_next.available = holds_free_next && (count_next != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      holds_free <= 1'b1;
      done       <= 1'b0;
    end else begin
      count      <= count_next;
      holds_free <= holds_free_next;
      done       <= accept;
    end
  end

  // result payload needs no reset, done qualifies it
  always_ff @(posedge clk) begin
    if (accept) begin
      result <= res_next;
    end
  end

  // the cell row: cell 0 is the front, neighbours feed each other on shifts
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic [CELL_W-1:0] left_val;
    logic [CELL_W-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_val = new_id;
    end else begin : g_mid_l
      assign left_val = cell_val[i-1];
    end

    if (i == LIST_DEPTH - 1) begin : g_last
      assign right_val = cell_val[i];
    end else begin : g_mid_r
      assign right_val = cell_val[i+1];
    end

    fla_cell #(
      .INDEX  (i),
      .CNT_W  (CNT_W),
      .CELL_W (CELL_W)
    ) u_cell (
      .clk       (clk),
      .op        (op),
      .count     (count),
      .new_id    (new_id),
      .left_val  (left_val),
      .right_val (right_val),
      .val       (cell_val[i])
    );
  end

endmodule

// ----- design/fla_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fla_checker
// port-level checks on the allocator, bound to the top level
// ----------------------------------------------------------------------------
module fla_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input fla_pkg::cmd_item_t    cmd,
  input logic                  done,
  input fla_pkg::result_item_t result
);
  import fla_pkg::*;

  // every accepted item answers in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("accepted item gave no result");

  // no result without an item
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("result without an item");

  // a queued requester means the list holds waiters, so nothing is available
  a_queued_blocks: assert property (@(posedge clk) disable iff (rst)
    (done && result.outcome == OUT_STORED && $past(cmd.func) == FUNC_ALLOC)
      |-> !result.available)
    else $error("available set after queueing a requester");

  // a failed try leaves nothing available
  a_none_unavail: assert property (@(posedge clk) disable iff (rst)
    (done && result.outcome == OUT_NONE) |-> !result.available)
    else $error("available set after none available");

  // a peek carries no ids
  a_peek_clean: assert property (@(posedge clk) disable iff (rst)
    (done && result.outcome == OUT_PEEK)
      |-> (result.entry_out == '0 && result.waiter_out == '0))
    else $error("peek result carries ids");

endmodule

bind free_list_allocator_with_waiters fla_checker u_fla_checker (.*);

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// testbench for the free list allocator with waiters: drives commands with a
// start / busy handshake, predicts each answer from its own model of the
// double-ended list and its mode flag, and checks every done strobe in order
// ----------------------------------------------------------------------------
module tb;
  import fla_pkg::*;

  localparam int LIST_DEPTH  = 64;
  localparam int ID_WIDTH    = 8;
  localparam int CYCLE_LIMIT = 200000;

  // clock, reset and the two payload structs
  logic         clk   = 1'b0;
  logic         rst   = 1'b1;
  logic         start = 1'b0;
  logic         busy;
  cmd_item_t    cmd   = '0;
  logic         done;
  result_item_t result;

  // model of the allocator: slots, front index, fill count and mode flag
  logic [ID_WIDTH-1:0] slots [LIST_DEPTH];
  logic [5:0]          front_idx  = '0;
  logic [6:0]          fill_count = '0;
  logic                free_mode  = 1'b1;

  // answers still owed by the block, oldest first
  result_item_t pending_answers [$];
  result_item_t want;

  int errors        = 0;
  int items_sent    = 0;
  int cycle_count   = 0;
  int sender_idle   = 0;   // percentage of items preceded by a gap
  int outcome_count [6];

  free_list_allocator_with_waiters #(
    .LIST_DEPTH(LIST_DEPTH),
    .ID_WIDTH  (ID_WIDTH)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done),
    .result(result)
  );

  always #6 clk = ~clk;

  // watchdog: a hung handshake or a lost answer ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // take the oldest id off the front of the list
  function automatic logic [ID_WIDTH-1:0] pop_oldest();
    logic [ID_WIDTH-1:0] v;
    v          = slots[front_idx];
    front_idx  = front_idx + 6'd1;
    fill_count = fill_count - 7'd1;
    return v;
  endfunction

  // one command applied to the model, giving the answer the block owes
  function automatic result_item_t allocator_step(input cmd_item_t c);
    result_item_t r;
    logic         full;
    logic [5:0]   back_idx;
    r         = '0;
    r.outcome = OUT_PEEK;
    full      = (fill_count >= LIST_DEPTH);
    back_idx  = front_idx + fill_count[5:0];
    case (c.func)
      FUNC_REL_FRONT, FUNC_REL_BACK: begin
        // an empty waiter list falls back to holding free entries
        if (!free_mode && fill_count == 0) free_mode = 1'b1;
        if (free_mode) begin
          if (full) begin
            r.outcome = OUT_OVERFLOW;
          end else begin
            if (c.func == FUNC_REL_FRONT) begin
              front_idx        = front_idx - 6'd1;
              slots[front_idx] = c.entry_id;
            end else begin
              slots[back_idx] = c.entry_id;
            end
            fill_count = fill_count + 7'd1;
            r.outcome  = OUT_STORED;
          end
        end else begin
          // hand the entry straight to the oldest waiter
          r.waiter_out = pop_oldest();
          r.entry_out  = c.entry_id;
          if (fill_count == 0) free_mode = 1'b1;
          r.outcome    = OUT_GRANTED;
        end
      end
      FUNC_ALLOC: begin
        if (!free_mode || fill_count == 0) begin
          if (full) begin
            r.outcome = OUT_OVERFLOW;
          end else begin
            slots[back_idx] = c.requester_id;
            fill_count      = fill_count + 7'd1;
            free_mode       = 1'b0;
            r.outcome       = OUT_STORED;
          end
        end else begin
          r.entry_out = pop_oldest();
          r.outcome   = OUT_RETURNED;
        end
      end
      FUNC_TRY: begin
        if (free_mode && fill_count != 0) begin
          r.entry_out = pop_oldest();
          r.outcome   = OUT_RETURNED;
        end else begin
          r.outcome = OUT_NONE;
        end
      end
      default: ;  // peek and unused codes leave the state alone
    endcase
    r.available = free_mode && (fill_count != 0);
    return r;
  endfunction

  task automatic report_field(input string name, input int exp_v, input int act_v);
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    errors++;
  endtask

  // checker: the answer on done is matched first, then an item taken at the
  // same edge is run through the model; the block registers its result, so the
  // answer seen here always belongs to an earlier item
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (pending_answers.size() == 0) begin
          $display("%0t ns: result with no item outstanding, actual %h", $time, result);
          errors++;
        end else begin
          want = pending_answers.pop_front();
          outcome_count[want.outcome]++;
          if (result.outcome !== want.outcome)
            report_field("outcome", want.outcome, result.outcome);
          if (result.entry_out !== want.entry_out)
            report_field("entry_out", want.entry_out, result.entry_out);
          if (result.waiter_out !== want.waiter_out)
            report_field("waiter_out", want.waiter_out, result.waiter_out);
          if (result.available !== want.available)
            report_field("available", want.available, result.available);
        end
      end
      if (start && !busy) pending_answers.push_back(allocator_step(cmd));
    end
  end

  // present one item and hold it until the block takes it; a gap, when one
  // is drawn, drops start on the edge that took the previous item
  task automatic send_item(input func_t f, input int entry, input int requester);
    if ($urandom_range(99) < sender_idle) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start            <= 1'b1;
    cmd.func         <= f;
    cmd.entry_id     <= entry[ID_WIDTH-1:0];
    cmd.requester_id <= requester[ID_WIDTH-1:0];
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // sender holds off until every owed answer has been checked
  task automatic wait_for_quiet();
    start <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  function automatic func_t release_func();
    return $urandom_range(1) ? FUNC_REL_BACK : FUNC_REL_FRONT;
  endfunction

  // extremes of the ids, every function, the unused codes, and the hand-over
  // from free entries to waiters and back when the last waiter is served
  task automatic test_directed();
    send_item(FUNC_PEEK, 0, 0);          // available low after reset
    send_item(FUNC_TRY, 0, 0);           // nothing to give yet
    send_item(FUNC_REL_FRONT, 0, 0);
    send_item(FUNC_REL_BACK, 255, 255);
    send_item(FUNC_REL_FRONT, 8'h5a, 8'ha5);
    send_item(FUNC_PEEK, 255, 255);
    send_item(FUNC_TRY, 255, 255);
    send_item(FUNC_ALLOC, 8'h33, 255);
    send_item(FUNC_TRY, 0, 0);
    send_item(FUNC_TRY, 0, 0);           // empty again
    send_item(FUNC_ALLOC, 0, 0);         // first waiter flips the mode
    send_item(FUNC_ALLOC, 255, 255);
    send_item(FUNC_TRY, 8'h12, 8'h34);   // waiters held, nothing to give
    send_item(FUNC_PEEK, 0, 0);
    send_item(FUNC_REL_FRONT, 8'h81, 8'h18);
    send_item(FUNC_REL_BACK, 8'h7e, 8'he7); // last waiter, back to free mode
    send_item(func_t'(3'd5), 255, 255);
    send_item(func_t'(3'd6), 8'haa, 8'h55);
    send_item(func_t'(3'd7), 0, 0);
    send_item(FUNC_REL_BACK, 255, 0);
    send_item(FUNC_ALLOC, 0, 8'haa);
    wait_for_quiet();
  endtask

  // fill the free list to the brim, overflow at both ends, then empty it
  task automatic test_free_list_full();
    repeat (LIST_DEPTH) send_item(release_func(), $urandom_range(255), $urandom_range(255));
    send_item(FUNC_REL_FRONT, $urandom_range(255), $urandom_range(255));
    send_item(FUNC_REL_BACK, $urandom_range(255), $urandom_range(255));
    send_item(FUNC_ALLOC, $urandom_range(255), $urandom_range(255)); // full yet pops
    send_item(release_func(), $urandom_range(255), $urandom_range(255));
    send_item(FUNC_PEEK, $urandom_range(255), $urandom_range(255));
    repeat (LIST_DEPTH)
      send_item($urandom_range(1) ? FUNC_TRY : FUNC_ALLOC, $urandom_range(255),
                $urandom_range(255));
    send_item(FUNC_TRY, $urandom_range(255), $urandom_range(255));
  endtask

  // queue a full list of waiters, overflow it, then serve every one of them
  task automatic test_waiter_list_full();
    repeat (LIST_DEPTH) send_item(FUNC_ALLOC, $urandom_range(255), $urandom_range(255));
    send_item(FUNC_ALLOC, $urandom_range(255), $urandom_range(255));
    send_item(FUNC_TRY, $urandom_range(255), $urandom_range(255));
    send_item(FUNC_PEEK, $urandom_range(255), $urandom_range(255));
    repeat (LIST_DEPTH) send_item(release_func(), $urandom_range(255), $urandom_range(255));
    send_item(release_func(), $urandom_range(255), $urandom_range(255));
    wait_for_quiet();
  endtask

  // random traffic in runs with a drifting mix, so the list wanders between
  // empty, full of free entries and full of waiters
  task automatic test_random_mix(input int idle_pct, input int count);
    int    rel_weight;
    int    run_left;
    int    pick;
    func_t f;
    sender_idle = idle_pct;
    run_left    = 0;
    rel_weight  = 50;
    for (int i = 0; i < count; i++) begin
      if (run_left == 0) begin
        run_left   = $urandom_range(40, 120);
        rel_weight = $urandom_range(12, 88);
      end
      run_left--;
      pick = $urandom_range(99);
      if (pick < 4)
        f = $urandom_range(3) == 0 ? func_t'($urandom_range(5, 7)) : FUNC_PEEK;
      else if ($urandom_range(99) < rel_weight)
        f = release_func();
      else
        f = $urandom_range(99) < 70 ? FUNC_ALLOC : FUNC_TRY;
      send_item(f, $urandom_range(255), $urandom_range(255));
      // now and then the sender waits for every answer before going on
      if ($urandom_range(149) == 0) wait_for_quiet();
    end
    wait_for_quiet();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    sender_idle = 25;
    test_directed();
    test_free_list_full();
    test_waiter_list_full();
    test_random_mix(25, 280);
    test_random_mix(60, 270);
    test_random_mix(0, 270);

    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("tb: %0d items over directed, full free list, full waiter list and random runs",
             items_sent);
    $display("tb: %0d stored, %0d granted, %0d returned, %0d none, %0d peeks, %0d overflows",
             outcome_count[OUT_STORED], outcome_count[OUT_GRANTED],
             outcome_count[OUT_RETURNED], outcome_count[OUT_NONE],
             outcome_count[OUT_PEEK], outcome_count[OUT_OVERFLOW]);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
